### src/kti_pkg.sv
// Shared types and constants for the keyframe track interpolator.
package kti_pkg;

  localparam int unsigned MaxKeysDef = 32;
  localparam int unsigned TimeW = 24;
  localparam int unsigned ValW = 32;
  localparam int unsigned CntW = 6;

  typedef enum logic [2:0] {
    OpInterp = 3'd0,
    OpSet    = 3'd1,
    OpAdd    = 3'd2,
    OpRemove = 3'd3,
    OpClear  = 3'd4,
    OpMove   = 3'd5,
    OpGet    = 3'd6,
    OpNone   = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StAbsent = 2'd1,
    StFull   = 2'd2
  } status_e;

  // Per-cell match flags and the values it sees.
  typedef struct packed {
    logic             valid;
    logic             eq;
    logic             le;
    logic [TimeW-1:0] t;
    logic [ValW-1:0]  v;
  } cell_view_t;

  // Shift command broadcast to all cells.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             wr;
    logic [TimeW-1:0] t;
    logic [ValW-1:0]  v;
  } cell_cmd_t;

endpackage

### src/kti_cell.sv
// One keyframe slot of the sorted chain; shifts with its neighbors.
module kti_cell import kti_pkg::*; (
  input  logic             clk_i,
  input  logic             valid_i,
  input  logic             at_pos_i,
  input  logic             after_pos_i,
  input  cell_cmd_t        cmd_i,
  input  logic [TimeW-1:0] prev_t_i,
  input  logic [ValW-1:0]  prev_v_i,
  input  logic [TimeW-1:0] next_t_i,
  input  logic [ValW-1:0]  next_v_i,
  input  logic [TimeW-1:0] probe_i,
  output cell_view_t       view_o
);

  logic [TimeW-1:0] t_q;
  logic [ValW-1:0]  v_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins && at_pos_i) begin
      t_q <= cmd_i.t;
      v_q <= cmd_i.v;
    end else if (cmd_i.ins && after_pos_i) begin
      t_q <= prev_t_i;
      v_q <= prev_v_i;
    end else if (cmd_i.del && (at_pos_i || after_pos_i)) begin
      t_q <= next_t_i;
      v_q <= next_v_i;
    end else if (cmd_i.wr && at_pos_i) begin
      v_q <= cmd_i.v;
    end
  end

  assign view_o.valid = valid_i;
  assign view_o.eq    = valid_i && (t_q == probe_i);
  assign view_o.le    = valid_i && (t_q <= probe_i);
  assign view_o.t     = t_q;
  assign view_o.v     = v_q;

endmodule

### src/kti_div.sv
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
module kti_div import kti_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [63:0]    num_i,
  input  logic [TimeW-1:0]      den_i,
  output logic                  done_o,
  output logic signed [63:0]    quo_o
);

  logic [63:0]      rem_q, quo_q;
  logic [TimeW-1:0] den_q;
  logic             neg_q, busy_q;
  logic [6:0]       cnt_q;
  logic [64:0]      trial;
  logic [64:0]      shifted;

  assign shifted = {rem_q, quo_q[63]};
  assign trial   = shifted - {41'd0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
        neg_q  <= num_i[63];
        quo_q  <= num_i[63] ? 64'(-num_i) : 64'(num_i);
        rem_q  <= '0;
        den_q  <= den_i;
      end else if (busy_q) begin
        if (!trial[64]) begin
          rem_q <= trial[63:0];
          quo_q <= {quo_q[62:0], 1'b1};
        end else begin
          rem_q <= shifted[63:0];
          quo_q <= {quo_q[62:0], 1'b0};
        end
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  assign quo_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

### src/keyframe_track_interpolator.sv
// Top level: keyframe table as a chain of cells, sequencer and divider.
//  channel | dir | fields (low bit up)
//  s_axis  | in  | tdata: opcode[2:0] key_time[26:3] new_time[50:27] key_value[82:51]
//  m_axis  | out | tdata: out_value[31:0] status[33:32] key_count[39:34]
//  cfg     | in  | default_value, written when cfg_we_i is high
// One item at a time, accept to accept; a move that relocates a key runs the lookup
// a second time, and an interpolation between keys waits for the divider.
// Async active-low reset empties the table and clears default_value.
// A held result stalls the next item only when it reaches its output step.
module keyframe_track_interpolator import kti_pkg::*; #(
  parameter int unsigned MAX_KEYS = MaxKeysDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // opcode, key_time, new_time, key_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // out_value, status, key_count
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned IdxW = $clog2(MAX_KEYS + 1);

  typedef enum logic [3:0] {
    SIdle, SLook, SMul, SDiv, SWaitDiv, SApply, SMove2, SMove3, SOut
  } state_e;

  state_e           state_q;
  logic [ValW-1:0]  dflt_q;
  logic [IdxW-1:0]  cnt_q;
  logic [2:0]       op_q;
  logic [TimeW-1:0] kt_q, nt_q;
  logic [ValW-1:0]  kv_q;
  logic [ValW-1:0]  res_q;
  logic [1:0]       st_q;
  logic [39:0]      out_q;
  logic             ovalid_q;

  logic [TimeW-1:0] probe;
  cell_view_t       view [MAX_KEYS];
  logic [MAX_KEYS-1:0] pos_oh, after;
  cell_cmd_t        cmd;

  // Search results (combinational over the cell flags).
  logic             hit;
  logic [IdxW-1:0]  hit_idx, upper;
  logic [ValW-1:0]  hit_v;

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    hit_v = '0;
    upper = '0;
    for (int i = 0; i < int'(MAX_KEYS); i++) begin
      if (view[i].eq) begin
        hit = 1'b1;
        hit_idx = IdxW'(i);
        hit_v = view[i].v;
      end
      if (view[i].le) upper = IdxW'(i + 1);
    end
  end

  logic [IdxW-1:0] sel_q;
  logic            ins_q, del_q, wr_q;
  logic [ValW-1:0] v1_q, v2_q;
  logic [TimeW-1:0] t1_q, dt_q;
  logic            dstart;
  logic            ddone;
  logic signed [63:0] dnum, dquo;
  logic signed [63:0] prod_q;
  logic signed [ValW:0]  vdiff;
  logic signed [TimeW:0] tdiff;
  logic signed [ValW+TimeW+1:0] prod;

  assign probe = (state_q == SLook && op_q == OpMove) ? nt_q : kt_q;

  always_comb begin
    for (int i = 0; i < int'(MAX_KEYS); i++) begin
      pos_oh[i] = (IdxW'(i) == sel_q);
      after[i]  = (IdxW'(i) > sel_q);
    end
  end

  assign cmd.ins = ins_q;
  assign cmd.del = del_q;
  assign cmd.wr  = wr_q;
  assign cmd.t   = kt_q;
  assign cmd.v   = kv_q;

  for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
    logic [TimeW-1:0] pt, ntt;
    logic [ValW-1:0]  pv, nv;
    if (g == 0) begin : g_first
      assign pt = '0;
      assign pv = '0;
    end else begin : g_mid
      assign pt = view[g-1].t;
      assign pv = view[g-1].v;
    end
    if (g == MAX_KEYS - 1) begin : g_last
      assign ntt = '0;
      assign nv  = '0;
    end else begin : g_nx
      assign ntt = view[g+1].t;
      assign nv  = view[g+1].v;
    end
    kti_cell u_cell (
      .clk_i      (clk_i),
      .valid_i    (IdxW'(g) < cnt_q),
      .at_pos_i   (pos_oh[g]),
      .after_pos_i(after[g]),
      .cmd_i      (cmd),
      .prev_t_i   (pt),
      .prev_v_i   (pv),
      .next_t_i   (ntt),
      .next_v_i   (nv),
      .probe_i    (probe),
      .view_o     (view[g])
    );
  end

  assign vdiff = $signed({v2_q[ValW-1], v2_q}) - $signed({v1_q[ValW-1], v1_q});
  assign tdiff = $signed({1'b0, kt_q - t1_q});
  assign prod  = vdiff * tdiff;

  assign dnum = prod_q;
  kti_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dstart),
    .num_i  (dnum),
    .den_i  (dt_q),
    .done_o (ddone),
    .quo_o  (dquo)
  );

  assign s_axis_tready = (state_q == SIdle);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;
  assign dstart = (state_q == SDiv);

  logic            full;
  assign full = (cnt_q >= IdxW'(MAX_KEYS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      dflt_q   <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      ins_q    <= 1'b0;
      del_q    <= 1'b0;
      wr_q     <= 1'b0;
    end else begin
      if (cfg_we_i) dflt_q <= cfg_wdata_i;
      if (m_axis_tready && state_q != SOut) ovalid_q <= 1'b0;
      ins_q <= 1'b0;
      del_q <= 1'b0;
      wr_q  <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (s_axis_tvalid) begin
            op_q    <= s_axis_tdata[2:0];
            kt_q    <= s_axis_tdata[26:3];
            nt_q    <= s_axis_tdata[50:27];
            kv_q    <= s_axis_tdata[82:51];
            res_q   <= '0;
            st_q    <= StOk;
            state_q <= SLook;
          end
        end
        SLook: begin
          state_q <= SApply;
          v1_q <= view[(upper == '0) ? 0 : int'(upper) - 1].v;
          t1_q <= view[(upper == '0) ? 0 : int'(upper) - 1].t;
          v2_q <= view[(upper >= cnt_q) ? 0 : int'(upper)].v;
          dt_q <= view[(upper >= cnt_q) ? 0 : int'(upper)].t
                  - view[(upper == '0) ? 0 : int'(upper) - 1].t;
          unique case (op_q)
            OpInterp, OpAdd: begin
              if (op_q == OpAdd && hit) begin
                st_q <= StAbsent;
                state_q <= SOut;
              end else if (op_q == OpAdd && full) begin
                st_q <= StFull;
                state_q <= SOut;
              end else if (cnt_q == '0) begin
                kv_q <= dflt_q;
              end else if (upper >= cnt_q) begin
                kv_q <= view[int'(cnt_q) - 1].v;
              end else if (upper == '0) begin
                kv_q <= view[0].v;
              end else begin
                state_q <= SMul;
              end
              sel_q <= upper;
            end
            OpSet: begin
              if (hit) begin
                sel_q <= hit_idx;
                wr_q <= 1'b1;
                state_q <= SOut;
              end else if (full) begin
                st_q <= StFull;
                state_q <= SOut;
              end else begin
                sel_q <= upper;
              end
            end
            OpRemove, OpGet: begin
              if (!hit) st_q <= StAbsent;
              else if (op_q == OpGet) res_q <= hit_v;
              sel_q <= hit_idx;
              state_q <= (hit && op_q == OpRemove) ? SApply : SOut;
            end
            OpClear: begin
              cnt_q <= '0;
              state_q <= SOut;
            end
            OpMove: begin
              if (hit) begin
                st_q <= StAbsent;
                state_q <= SOut;
              end else begin
                state_q <= SMove2;
              end
            end
            default: state_q <= SOut;
          endcase
        end
        SMul: begin
          prod_q <= 64'(prod);
          state_q <= SDiv;
        end
        SDiv: begin
          state_q <= SWaitDiv;
        end
        SWaitDiv: begin
          if (ddone) begin
            kv_q <= ValW'(signed'(v1_q) + dquo);
            state_q <= SApply;
          end
        end
        SMove2: begin
          // probe is the old key time; lift it out, then reinsert at new time
          state_q <= SOut;
          if (hit) begin
            kv_q <= hit_v;
            kt_q <= nt_q;
            sel_q <= hit_idx;
            del_q <= 1'b1;
            cnt_q <= cnt_q - IdxW'(1);
            op_q <= OpSet;
            state_q <= SMove3;
          end
        end
        SMove3: begin
          state_q <= SLook;
        end
        SApply: begin
          state_q <= SOut;
          if (op_q == OpRemove) begin
            del_q <= 1'b1;
            cnt_q <= cnt_q - IdxW'(1);
          end else if (op_q == OpInterp) begin
            res_q <= kv_q;
          end else if (op_q == OpSet || op_q == OpAdd) begin
            ins_q <= 1'b1;
            cnt_q <= cnt_q + IdxW'(1);
            if (op_q == OpAdd) res_q <= kv_q;
          end
        end
        SOut: begin
          if (!ovalid_q || m_axis_tready) begin
            out_q <= {CntW'(cnt_q), st_q, res_q};
            ovalid_q <= 1'b1;
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= IdxW'(MAX_KEYS)) else $error("key count overflow");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == SIdle) else $error("ready outside idle");
  a_ins_del: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ins_q && del_q)) else $error("insert and delete together");
`endif

endmodule
